FILE: hdl/sfm_pkg.sv
package sfm_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int MAX_TEXT_BYTES    = 65536;

  // Pattern storage as seen through the register file
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_BYTES    = 8;
  localparam int REG_BYTES     = PATTERN_WORDS * WORD_BYTES;
  localparam int PIDX_W        = $clog2(REG_BYTES);

  localparam int LEN_W  = 6;
  localparam int POS_W  = $clog2(MAX_TEXT_BYTES) + 1;
  localparam int OFF_W  = 16;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int REG_W  = 3;

  typedef enum logic [REG_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_0_7    = 3'd1,
    REG_PATTERN_8_15   = 3'd2,
    REG_PATTERN_16_23  = 3'd3,
    REG_PATTERN_24_31  = 3'd4
  } sfm_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_text;
    logic       empty_text;
  } sfm_in_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] match_offset;
    logic             text_overflow;
  } sfm_out_t;

  // Item handed from the cell row to the match tracker
  typedef struct packed {
    logic last_of_text;
    logic empty_text;
    logic all_eq;
  } sfm_stage_t;

endpackage

FILE: hdl/sfm_cell.sv
module sfm_cell
  import sfm_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       active,
  output logic [7:0] byte_out,
  output logic       eq
);

  // Window byte and the compare of the byte entering this position
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_out <= byte_in;
      eq       <= !active || (byte_in == pat_byte);
    end
  end

endmodule

FILE: hdl/sfm_tracker.sv
module sfm_tracker
  import sfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             move,
  input  sfm_stage_t       item,
  input  logic [LEN_W-1:0] pattern_length,
  input  logic             out_free,
  output logic             out_valid,
  output sfm_out_t         out_data
);

  logic [POS_W-1:0] bytes_seen, bytes_seen_next;
  logic             match_seen, match_seen_next;
  logic [OFF_W-1:0] first_offset, first_offset_next;
  logic             overflow_seen, overflow_seen_next;

  logic [POS_W-1:0] pos1;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] start;
  logic             in_range;
  logic             hit;
  logic             text_end;
  sfm_out_t         result;

  assign len_ext  = POS_W'(pattern_length);
  assign pos1     = bytes_seen + POS_W'(1);
  assign start    = pos1 - len_ext;
  assign in_range = bytes_seen < POS_W'(MAX_TEXT_BYTES);
  assign hit      = !match_seen && (pattern_length != '0)
                    && (pattern_length <= LEN_W'(MAX_PATTERN_BYTES))
                    && (pos1 >= len_ext) && item.all_eq;
  assign text_end = move && (item.last_of_text || item.empty_text);

  always_comb begin
    bytes_seen_next    = bytes_seen;
    match_seen_next    = match_seen;
    first_offset_next  = first_offset;
    overflow_seen_next = overflow_seen;
    if (move && !item.empty_text) begin
      if (in_range) begin
        bytes_seen_next = pos1;
        if (hit) begin
          match_seen_next   = 1'b1;
          first_offset_next = start[OFF_W-1:0];
        end
      end else begin
        overflow_seen_next = 1'b1;
      end
    end

    result.found         = (pattern_length == '0) || match_seen_next;
    result.match_offset  = (pattern_length != '0 && match_seen_next) ? first_offset_next : '0;
    result.text_overflow = overflow_seen_next;

    if (text_end) begin
      bytes_seen_next    = '0;
      match_seen_next    = 1'b0;
      first_offset_next  = '0;
      overflow_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      first_offset  <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      bytes_seen    <= bytes_seen_next;
      match_seen    <= match_seen_next;
      first_offset  <= first_offset_next;
      overflow_seen <= overflow_seen_next;
      if (out_free) begin
        out_valid <= text_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && text_end) begin
      out_data <= result;
    end
  end

endmodule

FILE: hdl/substring_first_match_finder.sv
// Streaming first-match substring search. Text arrives one byte per transaction on
// the input channel; a transaction with last_of_text (or empty_text) closes the text
// and produces exactly one result transaction: found, the start offset of the first
// occurrence and an overflow flag for texts longer than 65536 bytes. The pattern
// (0 to 32 bytes) and its length must be set over the APB port while the block is
// idle; the block does not enforce this. Registers sit at 8-byte spacing, 64-bit
// data. Throughput is one byte per clock while the input is not stalled: the byte
// enters a row of 32 cells that shifts the window and compares every position
// against the length-aligned pattern byte in the same edge, and the match tracker
// folds the registered flags into the per-text state as the compare stage moves on,
// loading the result register for a closing one. The input stalls only while a
// text-closing transaction waits in the compare stage behind an unaccepted result.
module substring_first_match_finder
  import sfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // text input
  input  logic              in_valid,
  output logic              in_stall,
  input  sfm_in_t           in_data,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output sfm_out_t          out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ---------------- configuration registers ----------------
  logic [LEN_W-1:0]  pattern_length;
  logic [DATA_W-1:0] pattern_words [PATTERN_WORDS];
  sfm_reg_t          reg_sel;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = sfm_reg_t'(paddr[ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_words[w] <= '0;
      end
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_PATTERN_LENGTH: pattern_length   <= pwdata[LEN_W-1:0];
        REG_PATTERN_0_7:    pattern_words[0] <= pwdata;
        REG_PATTERN_8_15:   pattern_words[1] <= pwdata;
        REG_PATTERN_16_23:  pattern_words[2] <= pwdata;
        REG_PATTERN_24_31:  pattern_words[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length);
      REG_PATTERN_0_7:    prdata = pattern_words[0];
      REG_PATTERN_8_15:   prdata = pattern_words[1];
      REG_PATTERN_16_23:  prdata = pattern_words[2];
      REG_PATTERN_24_31:  prdata = pattern_words[3];
      default:            prdata = '0;
    endcase
  end

  // pattern as a byte array, byte 0 lowest in word 0
  logic [7:0] pat_bytes [REG_BYTES];

  for (genvar k = 0; k < REG_BYTES; k++) begin : g_pat
    assign pat_bytes[k] = pattern_words[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
  end

  // ---------------- handshake and compare stage ----------------
  logic       s1_valid;
  logic       s1_last;
  logic       s1_empty;
  logic       s1_end;
  logic       s1_move;
  logic       out_free;
  logic       in_accept;
  logic       shift_en;
  sfm_stage_t s1_item;

  assign out_free  = !out_valid || !out_stall;
  assign s1_end    = s1_last || s1_empty;
  // a text-closing transaction may only leave when the output register is free
  assign s1_move   = s1_valid && (!s1_end || out_free);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;
  assign shift_en  = in_accept && !in_data.empty_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last  <= in_data.last_of_text;
      s1_empty <= in_data.empty_text;
    end
  end

  // ---------------- cell row ----------------
  // Cell j holds window byte j (0 = newest) and flags whether the byte shifted into
  // it equals pattern byte (len-1-j); cells at or beyond len always agree.
  logic [7:0]                   win   [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] eq;

  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    logic [7:0]       byte_in;
    logic [LEN_W-1:0] pidx;
    logic             active;

    if (j == 0) begin : g_head
      assign byte_in = in_data.text_byte;
    end else begin : g_body
      assign byte_in = win[j-1];
    end

    assign pidx   = pattern_length - LEN_W'(1) - LEN_W'(j);
    assign active = LEN_W'(j) < pattern_length;

    sfm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (byte_in),
      .pat_byte (pat_bytes[pidx[PIDX_W-1:0]]),
      .active   (active),
      .byte_out (win[j]),
      .eq       (eq[j])
    );
  end

  assign s1_item.last_of_text = s1_last;
  assign s1_item.empty_text   = s1_empty;
  assign s1_item.all_eq       = &eq;

  // ---------------- per-text match tracking and result register ----------------
  sfm_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .move           (s1_move),
    .item           (s1_item),
    .pattern_length (pattern_length),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_end && out_valid && out_stall)
    else $error("input stalled without a blocked closing transaction");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transaction lost before compare stage");

  a_offset_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_offset == '0)
    else $error("nonzero offset on a miss");

  a_empty_pattern_found: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_end && pattern_length == '0 && out_free |=> out_valid && out_data.found)
    else $error("empty pattern not reported as found");

endmodule
